// File: src/lspu_pkg.sv
package lspu_pkg;

  localparam int NSTEN = 25;
  localparam int NFEAT = 7;

  localparam logic [1:0] OP_WR_PHI     = 2'd0;
  localparam logic [1:0] OP_WR_FEAT    = 2'd1;
  localparam logic [1:0] OP_EVAL_INNER = 2'd2;
  localparam logic [1:0] OP_EVAL_OUTER = 2'd3;

  localparam logic [1:0] REG_TIME_STEP      = 2'd0;
  localparam logic [1:0] REG_CURVATURE_GAIN = 2'd1;
  localparam logic [1:0] REG_SPEED_GAIN     = 2'd2;
  localparam logic [1:0] REG_FAR_LEVEL      = 2'd3;

  localparam int CFG_W = 31;

  localparam logic signed [2:0] STN_DX [NSTEN] = '{
    0, 1, -1, 0, 0, 0, 0, 2, -2, 0, 0, 0, 0,
    1, 1, 0, -1, 1, -1, -1, 1, -1, 0, 0, 0};
  localparam logic signed [2:0] STN_DY [NSTEN] = '{
    0, 0, 0, 1, -1, 0, 0, 0, 0, 2, -2, 0, 0,
    1, 0, 1, 1, -1, -1, 0, 0, 0, -1, 1, -1};
  localparam logic signed [2:0] STN_DZ [NSTEN] = '{
    0, 0, 0, 0, 0, 1, -1, 0, 0, 0, 0, 2, -2,
    0, 1, 1, 0, 0, 0, 1, -1, -1, 1, -1, -1};

  typedef struct packed {
    logic [1:0]         operation;
    logic [5:0]         pos_x;
    logic [5:0]         pos_y;
    logic [5:0]         pos_z;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] update;
    logic               on_boundary;
    logic               sign_change;
  } out_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
    if (v > 70'sd2147483647) return 32'sh7fffffff;
    if (v < -70'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [69:0] qdiv(input logic signed [68:0] p);
    logic signed [69:0] e;
    e = 70'(p);
    if (e < 0) e = e + 70'sd65535;
    return e >>> 16;
  endfunction

  function automatic logic signed [31:0] qsat(input logic signed [68:0] p);
    return sat32(qdiv(p));
  endfunction

  function automatic logic signed [31:0] pos_part(input logic signed [31:0] v);
    return (v > 0) ? v : 32'sd0;
  endfunction

  function automatic logic signed [31:0] neg_part(input logic signed [31:0] v);
    return (v > 0) ? 32'sd0 : v;
  endfunction

endpackage

// File: src/level_set_point_update.sv
// Level set point update for a 3D geodesic active contour, Q16.16 fixed point.
// Phi and feature volumes live in two synchronous memories, each with one write and
// one read port, and are loaded with write items (a write beyond the volume is dropped).
// The memories are not cleared: a voxel must be written before it is used.
// An evaluate item reads its 25-point phi stencil and 7-point feature stencil, then
// runs through one shared multiplier: curvature normalization, a multiply phase,
// two 32-step square roots, a 64-step divide (skipped when all central differences
// are zero) and 6 final steps; a far-band
// outer point ends after the reads. One item is in work at a time, and a
// finished result waits in an output register while the next item is taken.
module level_set_point_update
  import lspu_pkg::*;
#(
  parameter int DIM_X = 64,
  parameter int DIM_Y = 64,
  parameter int DIM_Z = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int CWX = $clog2(DIM_X);
  localparam int CWY = $clog2(DIM_Y);
  localparam int CWZ = $clog2(DIM_Z);
  localparam int VOL = DIM_X * DIM_Y * DIM_Z;
  localparam int AW  = $clog2(VOL);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b00000001,
    ST_READ = 8'b00000010,
    ST_NORM = 8'b00000100,
    ST_MUL  = 8'b00001000,
    ST_SQRT = 8'b00010000,
    ST_DIV  = 8'b00100000,
    ST_POST = 8'b01000000,
    ST_FIN  = 8'b10000000
  } state_e;

  function automatic logic [11:0] clampc(input logic signed [12:0] t, input int dim);
    if (t < 0) return 12'd0;
    if (t > 13'(dim - 1)) return 12'(dim - 1);
    return t[11:0];
  endfunction

  function automatic logic [AW-1:0] vaddr(input logic [11:0] x, input logic [11:0] y,
                                          input logic [11:0] z);
    return AW'((32'(z) * DIM_Y + 32'(y)) * DIM_X + 32'(x));
  endfunction

  state_e state_q;

  logic [16:0]        ts_q;
  logic [20:0]        cg_q;
  logic signed [21:0] sg_q;
  logic [30:0]        far_q;

  logic           outer_q;
  logic [CWX-1:0] xc_q;
  logic [CWY-1:0] yc_q;
  logic [CWZ-1:0] zc_q;
  logic [4:0]     rd_q;
  logic [5:0]     step_q;
  logic [4:0]     s_q;
  logic           bnd_q;
  logic           zcurv_q;
  logic           second_q;

  logic signed [31:0] p_q [NSTEN];
  logic signed [31:0] f_q [NFEAT];
  logic signed [31:0] phi_rd_q;
  logic signed [31:0] feat_rd_q;

  logic signed [13:0] cx_q, cy_q, cz_q;
  logic signed [27:0] cxx_q, cyy_q, czz_q, cxy_q, cxz_q, cyz_q;
  logic signed [68:0] prod_q;
  logic signed [31:0] kf1_q, kf_q, g_q;
  logic signed [65:0] num_q;
  logic [66:0]        sp_q, sm_q;
  logic signed [34:0] t2_q, t1_q;
  logic signed [31:0] gp_q, gm_q, curv_q, upd_q;
  logic               sc_q;
  logic [63:0]        n_q, res_q, bit_q;
  logic [63:0]        dq_q;
  logic [30:0]        rem_q;
  logic [29:0]        den_q;
  logic               nneg_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic signed [31:0] phi_mem [VOL];
  logic signed [31:0] feat_mem [VOL];

  logic           acc;
  logic           wr_in;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;
  logic [4:0]     sidx;
  logic [11:0]    nx, ny, nz;

  assign in_stall_o = (state_q != ST_IDLE);
  assign acc = in_valid_i && !in_stall_o;
  assign wr_in = (32'(in_item_i.pos_x) < DIM_X) && (32'(in_item_i.pos_y) < DIM_Y)
              && (32'(in_item_i.pos_z) < DIM_Z);
  assign wr_addr = vaddr(12'(in_item_i.pos_x), 12'(in_item_i.pos_y), 12'(in_item_i.pos_z));

  assign sidx = (rd_q < 5'(NSTEN)) ? rd_q : 5'd0;
  assign nx = clampc($signed({1'b0, 12'(xc_q)}) + 13'(STN_DX[sidx]), DIM_X);
  assign ny = clampc($signed({1'b0, 12'(yc_q)}) + 13'(STN_DY[sidx]), DIM_Y);
  assign nz = clampc($signed({1'b0, 12'(zc_q)}) + 13'(STN_DZ[sidx]), DIM_Z);
  assign rd_addr = vaddr(nx, ny, nz);

  always_ff @(posedge clk_i) begin
    if (acc && wr_in && in_item_i.operation == OP_WR_PHI) begin
      phi_mem[wr_addr] <= in_item_i.value;
    end
    phi_rd_q <= phi_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (acc && wr_in && in_item_i.operation == OP_WR_FEAT) begin
      feat_mem[wr_addr] <= in_item_i.value;
    end
    feat_rd_q <= feat_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q  <= 17'd32768;
      cg_q  <= 21'd65536;
      sg_q  <= 22'sd65536;
      far_q <= 31'd327680;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TIME_STEP:      ts_q  <= cfg_data_i[16:0];
        REG_CURVATURE_GAIN: cg_q  <= cfg_data_i[20:0];
        REG_SPEED_GAIN:     sg_q  <= $signed(cfg_data_i[21:0]);
        REG_FAR_LEVEL:      far_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // stencil-derived values
  logic signed [31:0] fdx, bdx, fdy, bdy, fdz, bdz, kI, u, v, w;
  logic signed [32:0] c2x, c2y, c2z, hx, hy, hz;
  logic signed [34:0] dxx, dyy, dzz;
  logic signed [33:0] dxy, dxz, dyz;
  logic [32:0]        ax, ay, az, mx;
  logic signed [32:0] d33, far_s, p033;
  logic               hit;

  assign fdx = sat32(70'(33'(p_q[1]) - 33'(p_q[0])));
  assign bdx = sat32(70'(33'(p_q[0]) - 33'(p_q[2])));
  assign fdy = sat32(70'(33'(p_q[3]) - 33'(p_q[0])));
  assign bdy = sat32(70'(33'(p_q[0]) - 33'(p_q[4])));
  assign fdz = sat32(70'(33'(p_q[5]) - 33'(p_q[0])));
  assign bdz = sat32(70'(33'(p_q[0]) - 33'(p_q[6])));
  assign c2x = 33'(p_q[1]) - 33'(p_q[2]);
  assign c2y = 33'(p_q[3]) - 33'(p_q[4]);
  assign c2z = 33'(p_q[5]) - 33'(p_q[6]);
  assign dxx = 35'(p_q[7]) + 35'(p_q[8]) - (35'(p_q[0]) <<< 1);
  assign dyy = 35'(p_q[9]) + 35'(p_q[10]) - (35'(p_q[0]) <<< 1);
  assign dzz = 35'(p_q[11]) + 35'(p_q[12]) - (35'(p_q[0]) <<< 1);
  assign dxy = (34'(p_q[13]) - 34'(p_q[16])) - (34'(p_q[17]) - 34'(p_q[18]));
  assign dxz = (34'(p_q[14]) - 34'(p_q[19])) - (34'(p_q[20]) - 34'(p_q[21]));
  assign dyz = (34'(p_q[15]) - 34'(p_q[22])) - (34'(p_q[23]) - 34'(p_q[24]));
  assign ax = (c2x < 0) ? 33'(-c2x) : 33'(c2x);
  assign ay = (c2y < 0) ? 33'(-c2y) : 33'(c2y);
  assign az = (c2z < 0) ? 33'(-c2z) : 33'(c2z);
  assign mx = (ax >= ay && ax >= az) ? ax : ((ay >= az) ? ay : az);

  assign kI = f_q[0];
  assign hx = 33'(f_q[2]) - 33'(f_q[1]);
  assign hy = 33'(f_q[4]) - 33'(f_q[3]);
  assign hz = 33'(f_q[6]) - 33'(f_q[5]);
  assign u = 32'((hx < 0) ? ((hx + 33'sd1) >>> 1) : (hx >>> 1));
  assign v = 32'((hy < 0) ? ((hy + 33'sd1) >>> 1) : (hy >>> 1));
  assign w = 32'((hz < 0) ? ((hz + 33'sd1) >>> 1) : (hz >>> 1));

  assign d33   = 33'(phi_rd_q);
  assign p033  = 33'(p_q[0]);
  assign far_s = $signed({2'b00, far_q});
  assign hit = outer_q && (rd_q >= 5'd2)
            && (((p033 < 0) && (d33 <= -far_s)) || ((p033 > 0) && (d33 >= far_s)));

  function automatic logic signed [13:0] shr_mag(input logic signed [32:0] c,
                                                 input logic [4:0] s);
    logic [32:0] m;
    m = (c < 0) ? 33'(-c) : 33'(c);
    m = m >> s;
    return (c < 0) ? -$signed(14'(m)) : $signed(14'(m));
  endfunction

  // shared multiplier operand select
  logic signed [35:0] mul_a;
  logic signed [32:0] mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_MUL) begin
      case (step_q)
        6'd0:  begin mul_a = 36'(sg_q);  mul_b = 33'(kI); end
        6'd1:  begin mul_a = 36'($signed({1'b0, cg_q})); mul_b = 33'(kI); end
        6'd2:  begin mul_a = 36'(kf1_q); mul_b = 33'(kI); end
        6'd3:  begin mul_a = 36'(cx_q);  mul_b = 33'(cx_q); end
        6'd4:  begin mul_a = 36'(cy_q);  mul_b = 33'(cy_q); end
        6'd5:  begin mul_a = 36'(cz_q);  mul_b = 33'(cz_q); end
        6'd6:  begin mul_a = 36'(cx_q);  mul_b = 33'(cy_q); end
        6'd7:  begin mul_a = 36'(cx_q);  mul_b = 33'(cz_q); end
        6'd8:  begin mul_a = 36'(cy_q);  mul_b = 33'(cz_q); end
        6'd9:  begin mul_a = 36'(dyy) + 36'(dzz); mul_b = 33'(cxx_q); end
        6'd10: begin mul_a = 36'(dxx) + 36'(dzz); mul_b = 33'(cyy_q); end
        6'd11: begin mul_a = 36'(dxx) + 36'(dyy); mul_b = 33'(czz_q); end
        6'd12: begin mul_a = 36'(dxy); mul_b = 33'(cxy_q); end
        6'd13: begin mul_a = 36'(dxz); mul_b = 33'(cxz_q); end
        6'd14: begin mul_a = 36'(dyz); mul_b = 33'(cyz_q); end
        6'd15: begin mul_a = 36'(pos_part(bdx)); mul_b = 33'(pos_part(bdx)); end
        6'd16: begin mul_a = 36'(neg_part(fdx)); mul_b = 33'(neg_part(fdx)); end
        6'd17: begin mul_a = 36'(pos_part(bdy)); mul_b = 33'(pos_part(bdy)); end
        6'd18: begin mul_a = 36'(neg_part(fdy)); mul_b = 33'(neg_part(fdy)); end
        6'd19: begin mul_a = 36'(pos_part(bdz)); mul_b = 33'(pos_part(bdz)); end
        6'd20: begin mul_a = 36'(neg_part(fdz)); mul_b = 33'(neg_part(fdz)); end
        6'd21: begin mul_a = 36'(pos_part(fdx)); mul_b = 33'(pos_part(fdx)); end
        6'd22: begin mul_a = 36'(neg_part(bdx)); mul_b = 33'(neg_part(bdx)); end
        6'd23: begin mul_a = 36'(pos_part(fdy)); mul_b = 33'(pos_part(fdy)); end
        6'd24: begin mul_a = 36'(neg_part(bdy)); mul_b = 33'(neg_part(bdy)); end
        6'd25: begin mul_a = 36'(pos_part(fdz)); mul_b = 33'(pos_part(fdz)); end
        6'd26: begin mul_a = 36'(neg_part(bdz)); mul_b = 33'(neg_part(bdz)); end
        6'd27: begin mul_a = 36'(pos_part(u)); mul_b = 33'(bdx); end
        6'd28: begin mul_a = 36'(neg_part(u)); mul_b = 33'(fdx); end
        6'd29: begin mul_a = 36'(pos_part(v)); mul_b = 33'(bdy); end
        6'd30: begin mul_a = 36'(neg_part(v)); mul_b = 33'(fdy); end
        6'd31: begin mul_a = 36'(pos_part(w)); mul_b = 33'(bdz); end
        6'd32: begin mul_a = 36'(neg_part(w)); mul_b = 33'(fdz); end
        default: ;
      endcase
    end else if (state_q == ST_POST) begin
      case (step_q)
        6'd0: begin mul_a = 36'(pos_part(kf_q)); mul_b = 33'(gp_q); end
        6'd1: begin mul_a = 36'(neg_part(kf_q)); mul_b = 33'(gm_q); end
        6'd2: begin mul_a = 36'(g_q); mul_b = 33'(curv_q); end
        6'd4: begin mul_a = 36'($signed({1'b0, ts_q})); mul_b = 33'(upd_q); end
        default: ;
      endcase
    end
  end

  // square root and divide steps
  logic [63:0] rb_sum, res_nxt, n_nxt;
  logic [31:0] dtr;
  logic        dge;
  logic [63:0] dq_nxt;
  logic signed [31:0] gsat, curv_d;
  logic signed [31:0] t1s, t2s;
  logic signed [69:0] np;

  assign rb_sum  = res_q + bit_q;
  assign n_nxt   = (n_q >= rb_sum) ? n_q - rb_sum : n_q;
  assign res_nxt = (n_q >= rb_sum) ? (res_q >> 1) + bit_q : res_q >> 1;
  assign gsat    = (res_nxt > 64'h7fffffff) ? 32'sh7fffffff : $signed(res_nxt[31:0]);

  assign dtr    = {rem_q, dq_q[63]};
  assign dge    = dtr >= {den_q, 2'b00};
  assign dq_nxt = {dq_q[62:0], dge};
  assign curv_d = nneg_q ? ((dq_nxt > 64'h80000000) ? 32'sh80000000 : -$signed(dq_nxt[31:0]))
                         : ((dq_nxt > 64'h7fffffff) ? 32'sh7fffffff : $signed(dq_nxt[31:0]));

  assign t1s = sat32(70'(t1_q));
  assign t2s = sat32(70'(t2_q));
  assign np  = 70'(p_q[0]) + qdiv(prod_q);

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_q     <= '0;
      step_q   <= '0;
      s_q      <= '0;
      bnd_q    <= 1'b0;
      zcurv_q  <= 1'b0;
      second_q <= 1'b0;
      outer_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (acc && (in_item_i.operation == OP_EVAL_INNER
                      || in_item_i.operation == OP_EVAL_OUTER)) begin
            outer_q <= (in_item_i.operation == OP_EVAL_OUTER);
            rd_q    <= '0;
            bnd_q   <= 1'b0;
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          rd_q <= rd_q + 5'd1;
          if (hit) bnd_q <= 1'b1;
          if (rd_q == 5'(NSTEN)) begin
            s_q <= '0;
            state_q <= (hit || bnd_q) ? ST_FIN : ST_NORM;
          end
        end
        ST_NORM: begin
          if (mx != '0 && (mx >> s_q) >= 33'd8192) begin
            s_q <= s_q + 5'd1;
          end else begin
            zcurv_q <= (mx == '0);
            step_q  <= '0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          step_q <= step_q + 6'd1;
          if (step_q == 6'd33) begin
            second_q <= 1'b0;
            state_q  <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          rd_q <= rd_q + 5'd1;
          if (rd_q == 5'd31) begin
            second_q <= 1'b1;
            if (second_q) state_q <= zcurv_q ? ST_POST : ST_DIV;
          end
          step_q <= '0;
        end
        ST_DIV: begin
          step_q <= step_q + 6'd1;
          if (step_q == 6'd63) begin
            state_q <= ST_POST;
          end
        end
        ST_POST: begin
          step_q <= step_q + 6'd1;
          if (step_q == 6'd5) state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_q || !out_stall_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
      if (state_q == ST_MUL && step_q == 6'd33) rd_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      xc_q <= CWX'(clampc(13'(in_item_i.pos_x), DIM_X));
      yc_q <= CWY'(clampc(13'(in_item_i.pos_y), DIM_Y));
      zc_q <= CWZ'(clampc(13'(in_item_i.pos_z), DIM_Z));
    end
    case (state_q)
      ST_READ: begin
        if (rd_q >= 5'd1) p_q[5'(rd_q - 5'd1)] <= phi_rd_q;
        if (rd_q >= 5'd1 && rd_q <= 5'(NFEAT)) f_q[3'(rd_q - 5'd1)] <= feat_rd_q;
        upd_q <= '0;
        sc_q  <= 1'b0;
      end
      ST_NORM: begin
        cx_q <= shr_mag(c2x, s_q);
        cy_q <= shr_mag(c2y, s_q);
        cz_q <= shr_mag(c2z, s_q);
        curv_q <= '0;
      end
      ST_MUL: begin
        case (step_q)
          6'd0: begin
            num_q <= '0;
            sp_q  <= '0;
            sm_q  <= '0;
            t2_q  <= '0;
          end
          6'd1:  kf1_q <= qsat(prod_q);
          6'd2:  g_q   <= qsat(prod_q);
          6'd3:  kf_q  <= qsat(prod_q);
          6'd4:  cxx_q <= 28'(prod_q);
          6'd5:  cyy_q <= 28'(prod_q);
          6'd6:  czz_q <= 28'(prod_q);
          6'd7:  cxy_q <= 28'(prod_q);
          6'd8:  cxz_q <= 28'(prod_q);
          6'd9:  cyz_q <= 28'(prod_q);
          6'd10, 6'd11, 6'd12: num_q <= num_q + 66'(prod_q);
          6'd13, 6'd14, 6'd15: num_q <= num_q - (66'(prod_q) <<< 1);
          6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21:
            sp_q <= sp_q + 67'(prod_q[63:0]);
          6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27:
            sm_q <= sm_q + 67'(prod_q[63:0]);
          6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33:
            t2_q <= t2_q + 35'(qsat(prod_q));
          default: ;
        endcase
        if (step_q == 6'd33) begin
          n_q   <= (sp_q[66:64] != '0) ? '1 : sp_q[63:0];
          res_q <= '0;
          bit_q <= 64'h4000000000000000;
        end
      end
      ST_SQRT: begin
        if (rd_q == 5'd31 && !second_q) begin
          gp_q  <= gsat;
          n_q   <= (sm_q[66:64] != '0) ? '1 : sm_q[63:0];
          res_q <= '0;
          bit_q <= 64'h4000000000000000;
        end else begin
          n_q   <= n_nxt;
          res_q <= res_nxt;
          bit_q <= bit_q >> 2;
          if (rd_q == 5'd31) gm_q <= gsat;
        end
        nneg_q <= (num_q < 0);
        dq_q   <= (num_q < 0) ? 64'(-num_q) : 64'(num_q);
        rem_q  <= '0;
        den_q  <= 30'(cxx_q) + 30'(cyy_q) + 30'(czz_q);
      end
      ST_DIV: begin
        rem_q <= dge ? 31'(dtr - {den_q, 2'b00}) : 31'(dtr);
        dq_q  <= dq_nxt;
        if (step_q == 6'd63) curv_q <= curv_d;
      end
      ST_POST: begin
        case (step_q)
          6'd1: t1_q <= 35'(qsat(prod_q));
          6'd2: t1_q <= t1_q + 35'(qsat(prod_q));
          6'd3: upd_q <= sat32(70'(t1s) - 70'(t2s) + 70'(qsat(prod_q)));
          6'd5: sc_q <= outer_q && (((p_q[0] < 0) && (np > 0)) || ((p_q[0] > 0) && (np < 0)));
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FIN && (!out_valid_q || !out_stall_i)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && (!out_valid_q || !out_stall_i)) begin
      out_q.update      <= bnd_q ? 32'sd0 : upd_q;
      out_q.on_boundary <= bnd_q;
      out_q.sign_change <= bnd_q ? 1'b0 : sc_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("input taken while an item is in work");

  a_fin_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && !(out_valid_q && out_stall_i)) |=> out_valid_q)
    else $error("finished item not presented");

  a_bnd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.on_boundary) |->
      (out_item_o.update == 32'sd0 && !out_item_o.sign_change))
    else $error("far band item with nonzero update");

endmodule
